// ===== hw/rtl/hcei_pkg.sv =====
package hcei_pkg;

    localparam int NUM_ELEMS = 8;
    localparam int FRAC_BITS = 16;

    localparam int KW    = $clog2(NUM_ELEMS);
    localparam int FC_W  = $clog2(NUM_ELEMS + 1);
    localparam int WORD_W = 64;

    // divider: |num| has 33 bits, |den| 34 bits
    localparam int DVD_W = 33 + FRAC_BITS;
    localparam int REM_W = 35;
    localparam int CNT_W = $clog2(DVD_W + 1);

    // product of 33-bit |diff| and 32-bit |t|, split in two 32x17 halves
    localparam int PP_W  = 49;
    localparam int PROD_W = 65;
    localparam int MAG_W = PROD_W - FRAC_BITS;
    localparam int SUM_W = MAG_W + 2;

    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam int W_INDEX = 3;

    typedef enum logic [3:0] {
        S_LOAD,
        S_RD_AXIS,
        S_RD_W,
        S_GET_W,
        S_DIV_SETUP,
        S_DIV,
        S_EMIT_RD,
        S_EMIT_DAT,
        S_MUL_LO,
        S_MUL_HI,
        S_SUM,
        S_OUT
    } t_state;

    typedef struct packed {
        logic done;
        logic fault;
    } t_div_stat;

endpackage

// ===== hw/rtl/hcei_ram.sv =====
module hcei_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/hcei_div.sv =====
module hcei_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [32:0]      i_num,
    input  logic signed [33:0]      i_den,
    output logic signed [31:0]      o_t,
    output hcei_pkg::t_div_stat     o_stat
);
    import hcei_pkg::*;

    logic [DVD_W-1:0] r_dvd;
    logic [33:0]      r_dsr;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_fault;
    logic             r_neg;

    logic [32:0]      num_mag;
    logic [33:0]      den_mag;
    logic [REM_W-1:0] trial;
    logic             q_bit;

    assign num_mag = i_num[32] ? 33'(-i_num) : 33'(i_num);
    assign den_mag = i_den[33] ? 34'(-i_den) : 34'(i_den);
    assign trial   = {r_rem[REM_W-2:0], r_dvd[DVD_W-1]};
    assign q_bit   = (trial >= {1'b0, r_dsr});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_fault <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_dvd   <= {num_mag, {FRAC_BITS{1'b0}}};
                r_dsr   <= den_mag;
                r_rem   <= '0;
                r_cnt   <= CNT_W'(DVD_W);
                r_neg   <= i_num[32] ^ i_den[33];
                r_fault <= (i_den == '0);
                r_busy  <= (i_den != '0);
                r_done  <= (i_den == '0);
            end else if (r_busy) begin
                // restoring step: quotient bits shift in behind the dividend
                r_rem <= q_bit ? (trial - {1'b0, r_dsr}) : trial;
                r_dvd <= {r_dvd[DVD_W-2:0], q_bit};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_fault) begin
            o_t = '0;
        end else if (r_neg) begin
            if (r_dvd > DVD_W'(64'h8000_0000)) begin
                o_t = 32'sh8000_0000;
            end else begin
                o_t = 32'(-r_dvd[31:0]);
            end
        end else begin
            if (r_dvd > DVD_W'(64'h7FFF_FFFF)) begin
                o_t = 32'sh7FFF_FFFF;
            end else begin
                o_t = r_dvd[31:0];
            end
        end
    end

    assign o_stat.done  = r_done;
    assign o_stat.fault = r_fault;

endmodule

// ===== hw/rtl/homogeneous_clip_edge_interpolator_unit.sv =====
// Clips one edge against a near or far plane in homogeneous space. Feed the
// hidden/visible vertex pair one element per transfer (x, y, z, w, then
// attributes), flagging the final element with i_last_elem; up to NUM_ELEMS
// elements are kept, extras are dropped. After the last element the block
// reads the axis and w entries from the element RAM, runs a bit-serial
// restoring divide of 33+FRAC_BITS steps (49 at Q16.16) to get t, then emits
// each element as hidden + (visible - hidden) * t through the states EMIT_RD,
// EMIT_DAT, MUL_LO, MUL_HI, SUM and OUT, waiting in OUT for the output, the
// product taken as two 32x17 partial products on one multiplier. No new
// vertex is taken until the last result of the current one is accepted. A
// zero denominator gives t = 0 and flags div_fault on every result of that
// vertex.
module homogeneous_clip_edge_interpolator_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_elem_hidden,
    input  logic signed [31:0] i_elem_visible,
    input  logic [1:0]         i_clip_axis,
    input  logic               i_near_plane,
    input  logic               i_last_elem,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_elem_value,
    output logic [2:0]         o_elem_index,
    output logic               o_last_out,
    output logic               o_div_fault
);
    import hcei_pkg::*;

    t_state r_state, n_state;

    logic [FC_W-1:0]   r_fill;
    logic [KW-1:0]     r_k;
    logic [1:0]        r_axis;
    logic              r_near;
    logic signed [31:0] r_hi, r_vi, r_hw, r_vw;
    logic signed [31:0] r_t;
    logic              r_fault;
    logic [32:0]       r_md;
    logic              r_dneg;
    logic signed [31:0] r_hid;
    logic [PP_W-1:0]   r_p_lo, r_p_hi;
    logic              r_out_valid;
    logic signed [31:0] r_out_value;
    logic [2:0]        r_out_index;
    logic              r_out_last;
    logic              r_out_fault;

    logic              in_xfer, out_xfer;
    logic              ram_we;
    logic [KW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;
    logic              div_start;
    logic signed [31:0] div_t;
    t_div_stat         div_stat;

    logic signed [31:0] rd_h, rd_v;
    logic signed [32:0] di, dw, num;
    logic signed [33:0] den;
    logic signed [32:0] diff;
    logic [31:0]       mt;
    logic [16:0]       mul_b;
    logic [PP_W-1:0]   prod;
    logic [PROD_W-1:0] psum;
    logic [MAG_W-1:0]  smag;
    logic signed [SUM_W-1:0] hid_x, sum;
    logic signed [31:0] sat_val;
    logic              emit_last;

    assign in_xfer  = i_in_valid && o_in_ready;
    assign out_xfer = r_out_valid && i_out_ready;

    hcei_ram #(.WIDTH(WORD_W), .DEPTH(NUM_ELEMS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[KW-1:0]),
        .i_wdata ({i_elem_hidden, i_elem_visible}),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_h = ram_rdata[63:32];
    assign rd_v = ram_rdata[31:0];

    assign di = 33'(r_hi) - 33'(r_vi);
    assign dw = 33'(r_hw) - 33'(r_vw);
    assign num = r_near ? (33'(r_hi) + 33'(r_hw)) : (33'(r_hi) - 33'(r_hw));
    assign den = r_near ? (34'(dw) + 34'(di)) : (34'(di) - 34'(dw));

    hcei_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_t     (div_t),
        .o_stat  (div_stat)
    );

    assign diff  = 33'(rd_v) - 33'(rd_h);
    assign mt    = r_t[31] ? 32'(-r_t) : 32'(r_t);
    assign mul_b = (r_state == S_MUL_LO) ? r_md[16:0] : {1'b0, r_md[32:17]};
    assign prod  = PP_W'(mt) * PP_W'(mul_b);
    assign psum  = PROD_W'(r_p_lo) + (PROD_W'(r_p_hi) << 17);
    assign smag  = psum[PROD_W-1:FRAC_BITS];
    assign hid_x = SUM_W'(r_hid);
    assign sum   = r_dneg ? (hid_x - $signed({2'b00, smag}))
                          : (hid_x + $signed({2'b00, smag}));
    assign emit_last = ((FC_W'(r_k) + 1'b1) == r_fill);

    always_comb begin
        if (sum > SUM_W'(32'sh7FFF_FFFF)) begin
            sat_val = 32'sh7FFF_FFFF;
        end else if (sum < SUM_W'(32'sh8000_0000)) begin
            sat_val = 32'sh8000_0000;
        end else begin
            sat_val = sum[31:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_LOAD:      if (in_xfer && i_last_elem) n_state = S_RD_AXIS;
            S_RD_AXIS:   n_state = S_RD_W;
            S_RD_W:      n_state = S_GET_W;
            S_GET_W:     n_state = S_DIV_SETUP;
            S_DIV_SETUP: n_state = S_DIV;
            S_DIV:       if (div_stat.done) n_state = S_EMIT_RD;
            S_EMIT_RD:   n_state = S_EMIT_DAT;
            S_EMIT_DAT:  n_state = S_MUL_LO;
            S_MUL_LO:    n_state = S_MUL_HI;
            S_MUL_HI:    n_state = S_SUM;
            S_SUM:       n_state = S_OUT;
            S_OUT: begin
                if (out_xfer) n_state = r_out_last ? S_LOAD : S_EMIT_RD;
            end
            default:     n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_LOAD);
        ram_we     = in_xfer && (r_fill < FC_W'(NUM_ELEMS));
        div_start  = (r_state == S_DIV_SETUP);
        unique case (r_state)
            S_RD_AXIS: ram_raddr = KW'(r_axis);
            S_RD_W:    ram_raddr = KW'(W_INDEX);
            default:   ram_raddr = r_k;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ram_we) r_fill <= r_fill + 1'b1;
            if (r_state == S_SUM) r_out_valid <= 1'b1;
            if (out_xfer) begin
                r_out_valid <= 1'b0;
                if (r_out_last) r_fill <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && i_last_elem) begin
            r_axis <= (i_clip_axis > AXIS_Z) ? AXIS_Z : i_clip_axis;
            r_near <= i_near_plane;
        end
        // elements beyond the fill count read as zero
        if (r_state == S_RD_W) begin
            r_hi <= (FC_W'(r_axis) < r_fill) ? rd_h : '0;
            r_vi <= (FC_W'(r_axis) < r_fill) ? rd_v : '0;
        end
        if (r_state == S_GET_W) begin
            r_hw <= (FC_W'(W_INDEX) < r_fill) ? rd_h : '0;
            r_vw <= (FC_W'(W_INDEX) < r_fill) ? rd_v : '0;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_t     <= div_t;
            r_fault <= div_stat.fault;
            r_k     <= '0;
        end
        if (r_state == S_EMIT_DAT) begin
            r_hid  <= rd_h;
            r_md   <= diff[32] ? 33'(-diff) : 33'(diff);
            r_dneg <= diff[32] ^ r_t[31];
        end
        if (r_state == S_MUL_LO) r_p_lo <= prod;
        if (r_state == S_MUL_HI) r_p_hi <= prod;
        if (r_state == S_SUM) begin
            r_out_value <= sat_val;
            r_out_index <= 3'(r_k);
            r_out_last  <= emit_last;
            r_out_fault <= r_fault;
        end
        if (out_xfer && !r_out_last) r_k <= r_k + 1'b1;
    end

    assign o_out_valid  = r_out_valid;
    assign o_elem_value = r_out_value;
    assign o_elem_index = r_out_index;
    assign o_last_out   = r_out_last;
    assign o_div_fault  = r_out_fault;

    a_out_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && r_out_valid))
        else $error("input taken while result pending");

    a_fill_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_out_last) |=> (r_fill == '0))
        else $error("fill count not cleared after vertex");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FC_W'(NUM_ELEMS))
        else $error("fill count overflow");

endmodule
